// ===== rtl/i2c_humidity_sensor_reader_core_macros.svh =====
// assertion macros for the humidity sensor reader core
// expects signals named clock and reset in the scope of each use
`ifndef I2C_HUMIDITY_SENSOR_READER_CORE_MACROS_SVH
`define I2C_HUMIDITY_SENSOR_READER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// condition must hold on every clock edge out of reset
`define HSR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// consequent must hold on the edge after the antecedent
`define HSR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define HSR_ASSERT(lbl, prop, msg)
`define HSR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/i2chsr_pkg.sv =====
// shared types and constants for the humidity sensor reader core
// no dependencies
`default_nettype none

package i2chsr_pkg;

   // bus sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_START_A   = 4'd1,
      PH_START_B   = 4'd2,
      PH_TX        = 4'd3,
      PH_ACK_PRE   = 4'd4,
      PH_ACK_POLL  = 4'd5,
      PH_ACK_FILL  = 4'd6,
      PH_ACK_END   = 4'd7,
      PH_STOP_CMD  = 4'd8,
      PH_WAIT      = 4'd9,
      PH_RX_PRE    = 4'd10,
      PH_RX        = 4'd11,
      PH_MACK      = 4'd12,
      PH_STOP_END  = 4'd13
   } phase_type;

   // register map
   localparam logic [1:0] CSR_SENSOR_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_MEASURE_WAIT   = 2'd1;
   localparam logic [1:0] CSR_ACK_TIMEOUT    = 2'd2;

   localparam logic [6:0]  SENSOR_ADDRESS_RESET = 7'd68;
   localparam logic [15:0] MEASURE_WAIT_RESET   = 16'd50000;
   localparam logic [7:0]  ACK_TIMEOUT_RESET    = 8'd200;

   // single-shot measurement command, high repeatability with clock stretching
   localparam logic [7:0] CMD_MSB = 8'h2C;
   localparam logic [7:0] CMD_LSB = 8'h06;

   // fixed point conversion scales, divisor is full scale 65535
   localparam logic [30:0] TEMP_SPAN      = 31'd17500;
   localparam logic [29:0] HUM_SPAN       = 30'd10000;
   localparam logic [14:0] TEMP_OFFSET    = 15'd4500;
   localparam logic [16:0] FULL_SCALE     = 17'd65535;
   localparam logic [30:0] TEMP_RANGE_LO  = 31'(2500 * 65535);
   localparam logic [30:0] TEMP_RANGE_HI  = 31'(17000 * 65535);

endpackage

`default_nettype wire

// ===== rtl/i2c_humidity_sensor_reader_core.sv =====
// I2C humidity sensor reader: one measurement sequencer plus fixed point conversion
// depends on i2chsr_pkg and i2c_humidity_sensor_reader_core_macros.svh
//
// Each accepted item is one microsecond bus tick and yields exactly one result item
// carrying the line levels for that tick; one item per clock is sustained while the
// consumer keeps taking results, and each result appears in the output register on
// the clock after its item is taken. A new item is taken while the previous result
// waits, as long as the consumer takes that result in the same cycle. A measurement
// is a write of the command, a configurable wait, then a six byte read; the tick
// that ends it raises result_valid with raw words, hundredths and a range flag, all
// data being zero on other ticks. A missing acknowledge of the read address ends
// the cycle with read_nack and the previous stored bytes.
`default_nettype none
`include "i2c_humidity_sensor_reader_core_macros.svh"

module i2c_humidity_sensor_reader_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // tick items
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_begin_read,
   input  wire logic        req_sda_level,
   // result items
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_scl_level,
   output logic             rsp_sda_drive,
   output logic             rsp_sda_enable,
   output logic             rsp_busy_res,
   output logic             rsp_result_valid,
   output logic             rsp_read_nack,
   output logic [15:0]      rsp_temperature_raw,
   output logic [15:0]      rsp_humidity_raw,
   output logic signed [14:0] rsp_temperature_hundredths,
   output logic [13:0]      rsp_humidity_hundredths,
   output logic             rsp_in_range,
   // configuration
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   // configuration registers
   logic [6:0]  sensor_address_ff;
   logic [15:0] measure_wait_ff;
   logic [7:0]  ack_timeout_ff;

   // sequencer state
   i2chsr_pkg::phase_type phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [2:0]  byte_index_ff, byte_index_in;
   logic [7:0]  timeout_ff, timeout_in;
   logic [47:0] read_bytes_ff, read_bytes_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        en_ff, en_in;

   // conversion products
   logic [30:0] prod_t_ff, prod_t_in;
   logic [29:0] prod_h_ff, prod_h_in;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_scl_ff, rsp_sda_ff, rsp_en_ff, rsp_busy_ff, rsp_done_ff, rsp_nack_ff;
   logic [15:0] rsp_traw_ff, rsp_hraw_ff;
   logic [14:0] rsp_thun_ff;
   logic [13:0] rsp_hhun_ff;
   logic        rsp_range_ff;

   logic        accept;
   logic        start;
   i2chsr_pkg::phase_type ph;
   logic [15:0] tc, tc_inc;
   logic [2:0]  bi;
   logic [7:0]  tx_byte;
   logic [2:0]  rx_idx;
   logic [5:0]  rb_pos;
   logic [3:0]  bit_inc;
   logic [7:0]  shift_next;
   logic [7:0]  timeout_dec;
   logic        ack_fire, ack_ok;
   logic        busy, done, nack;

   logic [14:0] t_q0, t_q;
   logic [16:0] t_rem;
   logic [13:0] h_q0, h_q;
   logic [16:0] h_rem;
   logic [14:0] t_hun;
   logic        t_range;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_address_ff <= i2chsr_pkg::SENSOR_ADDRESS_RESET;
         measure_wait_ff   <= i2chsr_pkg::MEASURE_WAIT_RESET;
         ack_timeout_ff    <= i2chsr_pkg::ACK_TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            i2chsr_pkg::CSR_SENSOR_ADDRESS: sensor_address_ff <= csr_wdata[6:0];
            i2chsr_pkg::CSR_MEASURE_WAIT:   measure_wait_ff   <= csr_wdata;
            i2chsr_pkg::CSR_ACK_TIMEOUT:    ack_timeout_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // byte sent in the current write slot
   always_comb begin
      case (bi)
         3'd0:    tx_byte = {sensor_address_ff, 1'b0};
         3'd1:    tx_byte = i2chsr_pkg::CMD_MSB;
         3'd2:    tx_byte = i2chsr_pkg::CMD_LSB;
         default: tx_byte = {sensor_address_ff, 1'b1};
      endcase
   end

   // sequencer next state and line levels for this tick
   always_comb begin
      start         = (phase_ff == i2chsr_pkg::PH_IDLE) && req_begin_read;
      ph            = start ? i2chsr_pkg::PH_START_A : phase_ff;
      tc            = start ? 16'd0 : tick_ff;
      bi            = start ? 3'd0 : byte_index_ff;
      tc_inc        = tc + 16'd1;
      bit_inc       = bit_ff + 4'd1;
      shift_next    = {shift_ff[6:0], req_sda_level};
      timeout_dec   = timeout_ff - 8'd1;
      rx_idx        = (bi >= 3'd6) ? (bi - 3'd6) : bi;
      rb_pos        = {3'd5 - rx_idx, 3'b000};

      phase_in      = ph;
      tick_in       = tc;
      bit_in        = bit_ff;
      shift_in      = shift_ff;
      byte_index_in = bi;
      timeout_in    = timeout_ff;
      read_bytes_in = read_bytes_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      en_in         = en_ff;
      busy          = (ph != i2chsr_pkg::PH_IDLE);
      done          = 1'b0;
      nack          = 1'b0;
      ack_fire      = 1'b0;
      ack_ok        = 1'b0;

      case (ph)
         i2chsr_pkg::PH_START_A: begin
            en_in = 1'b1; sda_in = 1'b1; scl_in = 1'b1;
            tick_in = tc_inc;
            if (tc_inc >= 16'd4) begin
               phase_in = i2chsr_pkg::PH_START_B;
               tick_in  = 16'd0;
            end
         end
         i2chsr_pkg::PH_START_B: begin
            en_in = 1'b1; sda_in = 1'b0; scl_in = 1'b1;
            tick_in = tc_inc;
            if (tc_inc >= 16'd4) begin
               bit_in   = 4'd0;
               phase_in = i2chsr_pkg::PH_TX;
               tick_in  = 16'd0;
            end
         end
         i2chsr_pkg::PH_TX: begin
            en_in   = 1'b1;
            sda_in  = tx_byte[3'd7 - bit_ff[2:0]];
            scl_in  = (tc == 16'd2) || (tc == 16'd3);
            tick_in = tc_inc;
            if (tc_inc >= 16'd6) begin
               tick_in = 16'd0;
               bit_in  = bit_inc;
               if (bit_inc >= 4'd8) begin
                  bit_in   = 4'd0;
                  phase_in = i2chsr_pkg::PH_ACK_PRE;
               end
            end
         end
         i2chsr_pkg::PH_ACK_PRE: begin
            if (tc == 16'd0) timeout_in = ack_timeout_ff;
            sda_in  = 1'b1;
            scl_in  = 1'b0;
            en_in   = (tc != 16'd2);
            tick_in = tc_inc;
            if (tc_inc >= 16'd3) begin
               phase_in = i2chsr_pkg::PH_ACK_POLL;
               tick_in  = 16'd0;
            end
         end
         i2chsr_pkg::PH_ACK_POLL: begin
            en_in  = 1'b0;
            scl_in = 1'b0;
            if (!req_sda_level) begin
               phase_in = i2chsr_pkg::PH_ACK_END;
               tick_in  = 16'd1;
            end else begin
               timeout_in = timeout_dec;
               if (timeout_dec == 8'd0) begin
                  ack_fire = 1'b1;
               end else begin
                  phase_in = i2chsr_pkg::PH_ACK_FILL;
                  tick_in  = 16'd0;
               end
            end
         end
         i2chsr_pkg::PH_ACK_FILL: begin
            en_in    = 1'b0;
            scl_in   = 1'b0;
            phase_in = i2chsr_pkg::PH_ACK_POLL;
            tick_in  = 16'd0;
         end
         i2chsr_pkg::PH_ACK_END: begin
            en_in   = 1'b0;
            scl_in  = (tc == 16'd1);
            tick_in = tc_inc;
            if (tc_inc >= 16'd3) begin
               ack_fire = 1'b1;
               ack_ok   = 1'b1;
            end
         end
         i2chsr_pkg::PH_STOP_CMD, i2chsr_pkg::PH_STOP_END: begin
            en_in   = 1'b1;
            scl_in  = (tc >= 16'd4);
            sda_in  = (tc >= 16'd8);
            tick_in = tc_inc;
            if (tc_inc >= 16'd12) begin
               if (ph == i2chsr_pkg::PH_STOP_END) begin
                  done     = 1'b1;
                  phase_in = i2chsr_pkg::PH_IDLE;
                  tick_in  = 16'd0;
               end else begin
                  byte_index_in = 3'd3;
                  phase_in      = i2chsr_pkg::PH_WAIT;
                  tick_in       = measure_wait_ff;
               end
            end
         end
         i2chsr_pkg::PH_WAIT: begin
            en_in = 1'b1; scl_in = 1'b1; sda_in = 1'b1;
            tick_in = tc - 16'd1;
            if (tick_in == 16'd0) phase_in = i2chsr_pkg::PH_START_A;
         end
         i2chsr_pkg::PH_RX_PRE: begin
            en_in    = 1'b0;
            scl_in   = 1'b0;
            bit_in   = 4'd0;
            shift_in = 8'd0;
            phase_in = i2chsr_pkg::PH_RX;
            tick_in  = 16'd0;
         end
         i2chsr_pkg::PH_RX: begin
            en_in = 1'b0;
            if (tc < 16'd2) begin
               scl_in  = 1'b0;
               tick_in = tc_inc;
            end else begin
               scl_in   = 1'b1;
               shift_in = shift_next;
               tick_in  = 16'd0;
               bit_in   = bit_inc;
               if (bit_inc >= 4'd8) begin
                  read_bytes_in[rb_pos +: 8] = shift_next;
                  bit_in   = 4'd0;
                  phase_in = i2chsr_pkg::PH_MACK;
               end
            end
         end
         i2chsr_pkg::PH_MACK: begin
            en_in = 1'b1;
            if (tc >= 16'd2) sda_in = (bi >= 3'd5);
            scl_in  = (tc == 16'd4) || (tc == 16'd5);
            tick_in = tc_inc;
            if (tc_inc >= 16'd7) begin
               tick_in = 16'd0;
               if (bi >= 3'd5) begin
                  phase_in = i2chsr_pkg::PH_STOP_END;
               end else begin
                  byte_index_in = bi + 3'd1;
                  phase_in      = i2chsr_pkg::PH_RX_PRE;
               end
            end
         end
         default: ;
      endcase

      // end of an acknowledge slot
      if (ack_fire) begin
         tick_in = 16'd0;
         if (bi < 3'd2) begin
            byte_index_in = bi + 3'd1;
            bit_in        = 4'd0;
            phase_in      = i2chsr_pkg::PH_TX;
         end else if (bi == 3'd2) begin
            phase_in = i2chsr_pkg::PH_STOP_CMD;
         end else if (ack_ok) begin
            byte_index_in = 3'd0;
            phase_in      = i2chsr_pkg::PH_RX_PRE;
         end else begin
            phase_in = i2chsr_pkg::PH_IDLE;
            done     = 1'b1;
            nack     = 1'b1;
         end
      end
   end

   // sequencer registers advance once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2chsr_pkg::PH_IDLE;
         tick_ff       <= 16'd0;
         bit_ff        <= 4'd0;
         shift_ff      <= 8'd0;
         byte_index_ff <= 3'd0;
         timeout_ff    <= 8'd0;
         read_bytes_ff <= 48'd0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         en_ff         <= 1'b1;
      end else if (accept) begin
         phase_ff      <= phase_in;
         tick_ff       <= tick_in;
         bit_ff        <= bit_in;
         shift_ff      <= shift_in;
         byte_index_ff <= byte_index_in;
         timeout_ff    <= timeout_in;
         read_bytes_ff <= read_bytes_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         en_ff         <= en_in;
      end
   end

   // scale products, registered from the stored bytes
   assign prod_t_in = 31'(read_bytes_ff[47:32]) * i2chsr_pkg::TEMP_SPAN;
   assign prod_h_in = 30'(read_bytes_ff[23:8]) * i2chsr_pkg::HUM_SPAN;

   always_ff @(posedge clock) begin
      prod_t_ff <= prod_t_in;
      prod_h_ff <= prod_h_in;
   end

   // divide by 65535: high half plus one correction step
   always_comb begin
      t_q0    = prod_t_ff[30:16];
      t_rem   = {1'b0, prod_t_ff[15:0]} + {2'b00, t_q0};
      t_q     = t_q0 + ((t_rem >= i2chsr_pkg::FULL_SCALE) ? 15'd1 : 15'd0);
      t_hun   = t_q - i2chsr_pkg::TEMP_OFFSET;
      h_q0    = prod_h_ff[29:16];
      h_rem   = {1'b0, prod_h_ff[15:0]} + {3'b000, h_q0};
      h_q     = h_q0 + ((h_rem >= i2chsr_pkg::FULL_SCALE) ? 14'd1 : 14'd0);
      t_range = (prod_t_ff >= i2chsr_pkg::TEMP_RANGE_LO)
             && (prod_t_ff <= i2chsr_pkg::TEMP_RANGE_HI);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_scl_ff   <= scl_in;
         rsp_sda_ff   <= sda_in;
         rsp_en_ff    <= en_in;
         rsp_busy_ff  <= busy;
         rsp_done_ff  <= done;
         rsp_nack_ff  <= nack;
         rsp_traw_ff  <= done ? read_bytes_ff[47:32] : 16'd0;
         rsp_hraw_ff  <= done ? read_bytes_ff[23:8] : 16'd0;
         rsp_thun_ff  <= done ? t_hun : 15'd0;
         rsp_hhun_ff  <= done ? h_q : 14'd0;
         rsp_range_ff <= done && t_range;
      end
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_scl_level              = rsp_scl_ff;
   assign rsp_sda_drive              = rsp_sda_ff;
   assign rsp_sda_enable             = rsp_en_ff;
   assign rsp_busy_res               = rsp_busy_ff;
   assign rsp_result_valid           = rsp_done_ff;
   assign rsp_read_nack              = rsp_nack_ff;
   assign rsp_temperature_raw        = rsp_traw_ff;
   assign rsp_humidity_raw           = rsp_hraw_ff;
   assign rsp_temperature_hundredths = signed'(rsp_thun_ff);
   assign rsp_humidity_hundredths    = rsp_hhun_ff;
   assign rsp_in_range               = rsp_range_ff;

   // checks on the sequencer and the result register
   `HSR_ASSERT(a_bit_count_bound, bit_ff[3] == 1'b0, "bit counter reached eight")
   `HSR_ASSERT(a_byte_index_bound, !(byte_index_ff == 3'd6 || byte_index_ff == 3'd7), "byte index past last read byte")
   `HSR_ASSERT(a_done_while_busy, !(rsp_valid_ff && rsp_done_ff) || rsp_busy_ff, "cycle end reported while not busy")
   `HSR_ASSERT(a_nack_ends_cycle, !(rsp_valid_ff && rsp_nack_ff) || rsp_done_ff, "read nack without cycle end")
   `HSR_ASSERT_NEXT(a_stop_leaves_bus_idle, accept && done && !nack, rsp_scl_ff && rsp_sda_ff && rsp_en_ff, "bus not released high after stop")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// testbench for the i2c humidity sensor reader core: tick-by-tick bus levels and readings
// depends on i2chsr_pkg and the core; the sensor side is played by the bench itself
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 50_000;
   localparam int unsigned RANDOM_TICKS_PER_MODE = 100;
   localparam int unsigned PRESSURE_TICKS = 200;

   // one expected bus tick
   typedef struct packed {
      logic        scl;
      logic        sda;
      logic        en;
      logic        busy;
      logic        done;
      logic        nack;
      logic [15:0] temp_raw;
      logic [15:0] hum_raw;
      logic [14:0] temp_c100;
      logic [13:0] hum_c100;
      logic        in_range;
   } bus_tick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_begin_read = 1'b0;
   logic req_sda_level = 1'b1;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_scl_level;
   logic rsp_sda_drive;
   logic rsp_sda_enable;
   logic rsp_busy_res;
   logic rsp_result_valid;
   logic rsp_read_nack;
   logic [15:0] rsp_temperature_raw;
   logic [15:0] rsp_humidity_raw;
   logic signed [14:0] rsp_temperature_hundredths;
   logic [13:0] rsp_humidity_hundredths;
   logic rsp_in_range;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = i2chsr_pkg::CSR_SENSOR_ADDRESS;
   logic [15:0] csr_wdata = 16'd0;

   i2c_humidity_sensor_reader_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_begin_read(req_begin_read),
      .req_sda_level(req_sda_level),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_scl_level(rsp_scl_level),
      .rsp_sda_drive(rsp_sda_drive),
      .rsp_sda_enable(rsp_sda_enable),
      .rsp_busy_res(rsp_busy_res),
      .rsp_result_valid(rsp_result_valid),
      .rsp_read_nack(rsp_read_nack),
      .rsp_temperature_raw(rsp_temperature_raw),
      .rsp_humidity_raw(rsp_humidity_raw),
      .rsp_temperature_hundredths(rsp_temperature_hundredths),
      .rsp_humidity_hundredths(rsp_humidity_hundredths),
      .rsp_in_range(rsp_in_range),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // bench-side copy of the registers
   logic [6:0]  reg_address = i2chsr_pkg::SENSOR_ADDRESS_RESET;
   logic [15:0] reg_wait = i2chsr_pkg::MEASURE_WAIT_RESET;
   logic [7:0]  reg_timeout = i2chsr_pkg::ACK_TIMEOUT_RESET;

   // bench-side copy of the sequencer state
   i2chsr_pkg::phase_type bus_phase = i2chsr_pkg::PH_IDLE;
   logic [15:0] bus_tick = '0;
   logic [3:0]  bit_pos = '0;
   logic [7:0]  shift_reg = '0;
   logic [2:0]  byte_pos = '0;
   logic [7:0]  ack_budget = '0;
   logic [47:0] sensor_words = '0;
   logic        line_scl = 1'b1;
   logic        line_sda = 1'b1;
   logic        line_en = 1'b1;

   // sensor behaviour for the current measurement
   logic [7:0]  sensor_bytes [6];
   int unsigned ack_pct_write = 100;
   int unsigned ack_pct_read = 100;

   bus_tick_type pending_ticks [$];
   int unsigned sent_ticks = 0;
   int unsigned fault_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned take_idle_pct = 0;
   int unsigned hold_request = 0;
   int unsigned hold_left = 0;

   function automatic void go_phase(input i2chsr_pkg::phase_type p);
      bus_phase = p;
      bus_tick = '0;
   endfunction

   function automatic logic [7:0] outgoing_byte();
      case (byte_pos)
         3'd0: return {reg_address, 1'b0};
         3'd1: return i2chsr_pkg::CMD_MSB;
         3'd2: return i2chsr_pkg::CMD_LSB;
         default: return {reg_address, 1'b1};
      endcase
   endfunction

   // end of an acknowledge slot; returns 1 when the read address went unanswered
   function automatic logic ack_finish(input logic acked);
      if (byte_pos < 3'd2) begin
         byte_pos = byte_pos + 3'd1;
         bit_pos = '0;
         go_phase(i2chsr_pkg::PH_TX);
      end else if (byte_pos == 3'd2) begin
         go_phase(i2chsr_pkg::PH_STOP_CMD);
      end else if (acked) begin
         byte_pos = '0;
         go_phase(i2chsr_pkg::PH_RX_PRE);
      end else begin
         go_phase(i2chsr_pkg::PH_IDLE);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // advance the sequencer by one tick and give the levels and reading it yields
   function automatic bus_tick_type advance_bus(input logic start, input logic sda_in);
      bus_tick_type r;
      logic [15:0] t;
      logic [7:0] tx;
      int sh;
      int unsigned prod;
      r = '0;
      if (bus_phase == i2chsr_pkg::PH_IDLE && start) begin
         byte_pos = '0;
         go_phase(i2chsr_pkg::PH_START_A);
      end
      r.busy = (bus_phase != i2chsr_pkg::PH_IDLE);
      t = bus_tick;
      case (bus_phase)
         i2chsr_pkg::PH_START_A: begin
            line_en = 1'b1; line_sda = 1'b1; line_scl = 1'b1;
            bus_tick = bus_tick + 16'd1;
            if (bus_tick >= 16'd4) go_phase(i2chsr_pkg::PH_START_B);
         end
         i2chsr_pkg::PH_START_B: begin
            line_en = 1'b1; line_sda = 1'b0; line_scl = 1'b1;
            bus_tick = bus_tick + 16'd1;
            if (bus_tick >= 16'd4) begin
               bit_pos = '0;
               go_phase(i2chsr_pkg::PH_TX);
            end
         end
         i2chsr_pkg::PH_TX: begin
            tx = outgoing_byte();
            line_en = 1'b1;
            line_sda = tx[3'd7 - bit_pos[2:0]];
            line_scl = (t == 16'd2 || t == 16'd3);
            bus_tick = bus_tick + 16'd1;
            if (bus_tick >= 16'd6) begin
               bus_tick = '0;
               bit_pos = bit_pos + 4'd1;
               if (bit_pos >= 4'd8) begin
                  bit_pos = '0;
                  go_phase(i2chsr_pkg::PH_ACK_PRE);
               end
            end
         end
         i2chsr_pkg::PH_ACK_PRE: begin
            if (t == 16'd0) ack_budget = reg_timeout;
            line_sda = 1'b1; line_scl = 1'b0;
            line_en = (t == 16'd2) ? 1'b0 : 1'b1;
            bus_tick = bus_tick + 16'd1;
            if (bus_tick >= 16'd3) go_phase(i2chsr_pkg::PH_ACK_POLL);
         end
         i2chsr_pkg::PH_ACK_POLL: begin
            line_en = 1'b0; line_scl = 1'b0;
            if (!sda_in) begin
               go_phase(i2chsr_pkg::PH_ACK_END);
               bus_tick = 16'd1;
            end else begin
               ack_budget = ack_budget - 8'd1;
               if (ack_budget == 8'd0) begin
                  if (ack_finish(1'b0)) begin
                     r.done = 1'b1;
                     r.nack = 1'b1;
                  end
               end else begin
                  go_phase(i2chsr_pkg::PH_ACK_FILL);
               end
            end
         end
         i2chsr_pkg::PH_ACK_FILL: begin
            line_en = 1'b0; line_scl = 1'b0;
            go_phase(i2chsr_pkg::PH_ACK_POLL);
         end
         i2chsr_pkg::PH_ACK_END: begin
            line_en = 1'b0;
            line_scl = (t == 16'd1);
            bus_tick = bus_tick + 16'd1;
            if (bus_tick >= 16'd3) void'(ack_finish(1'b1));
         end
         i2chsr_pkg::PH_STOP_CMD, i2chsr_pkg::PH_STOP_END: begin
            line_en = 1'b1;
            line_scl = (t >= 16'd4);
            line_sda = (t >= 16'd8);
            bus_tick = bus_tick + 16'd1;
            if (bus_tick >= 16'd12) begin
               if (bus_phase == i2chsr_pkg::PH_STOP_END) begin
                  r.done = 1'b1;
                  go_phase(i2chsr_pkg::PH_IDLE);
               end else begin
                  byte_pos = 3'd3;
                  go_phase(i2chsr_pkg::PH_WAIT);
                  bus_tick = reg_wait;
               end
            end
         end
         i2chsr_pkg::PH_WAIT: begin
            line_en = 1'b1; line_scl = 1'b1; line_sda = 1'b1;
            bus_tick = bus_tick - 16'd1;
            if (bus_tick == 16'd0) go_phase(i2chsr_pkg::PH_START_A);
         end
         i2chsr_pkg::PH_RX_PRE: begin
            line_en = 1'b0; line_scl = 1'b0;
            bit_pos = '0;
            shift_reg = '0;
            go_phase(i2chsr_pkg::PH_RX);
         end
         i2chsr_pkg::PH_RX: begin
            line_en = 1'b0;
            if (t < 16'd2) begin
               line_scl = 1'b0;
               bus_tick = bus_tick + 16'd1;
            end else begin
               line_scl = 1'b1;
               shift_reg = {shift_reg[6:0], sda_in};
               bus_tick = '0;
               bit_pos = bit_pos + 4'd1;
               if (bit_pos >= 4'd8) begin
                  sh = (5 - int'(byte_pos)) * 8;
                  sensor_words[sh +: 8] = shift_reg;
                  bit_pos = '0;
                  go_phase(i2chsr_pkg::PH_MACK);
               end
            end
         end
         i2chsr_pkg::PH_MACK: begin
            line_en = 1'b1;
            if (t >= 16'd2) line_sda = (byte_pos >= 3'd5);
            line_scl = (t == 16'd4 || t == 16'd5);
            bus_tick = bus_tick + 16'd1;
            if (bus_tick >= 16'd7) begin
               if (byte_pos >= 3'd5) begin
                  go_phase(i2chsr_pkg::PH_STOP_END);
               end else begin
                  byte_pos = byte_pos + 3'd1;
                  go_phase(i2chsr_pkg::PH_RX_PRE);
               end
            end
         end
         default: ;
      endcase
      r.scl = line_scl;
      r.sda = line_sda;
      r.en = line_en;
      // reading appears only on the closing tick
      if (r.done) begin
         r.temp_raw = sensor_words[47:32];
         r.hum_raw = sensor_words[23:8];
         prod = 32'd17500 * {16'd0, r.temp_raw};
         r.temp_c100 = 15'(int'(prod / 32'd65535) - 4500);
         r.hum_c100 = 14'((32'd10000 * {16'd0, r.hum_raw}) / 32'd65535);
         r.in_range = (prod >= 32'd2500 * 32'd65535) && (prod <= 32'd17000 * 32'd65535);
      end
      return r;
   endfunction

   // level the sensor puts on sda for the coming tick
   function automatic logic sensor_sda();
      logic [7:0] b;
      if (bus_phase == i2chsr_pkg::PH_ACK_POLL) begin
         if ($urandom_range(0, 99) < ((byte_pos == 3'd3) ? ack_pct_read : ack_pct_write))
            return 1'b0;
         return 1'b1;
      end
      if (bus_phase == i2chsr_pkg::PH_RX && bus_tick >= 16'd2) begin
         b = sensor_bytes[byte_pos];
         return b[3'd7 - bit_pos[2:0]];
      end
      return 1'($urandom_range(0, 1));
   endfunction

   // raw word, often one at the scale ends or beside a range limit
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 11))
         0: return 16'd0;
         1: return 16'd9362;
         2: return 16'd9363;
         3: return 16'd63662;
         4: return 16'd63663;
         5: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic plan_reading(input logic [15:0] temp, input logic [15:0] hum);
      sensor_bytes[0] = temp[15:8];
      sensor_bytes[1] = temp[7:0];
      sensor_bytes[2] = 8'($urandom_range(0, 255));
      sensor_bytes[3] = hum[15:8];
      sensor_bytes[4] = hum[7:0];
      sensor_bytes[5] = 8'($urandom_range(0, 255));
   endtask

   // offer one tick item, wait for it to be taken, then record what it should yield
   task automatic send_tick(input logic start, input logic sda);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_begin_read <= start;
      req_sda_level <= sda;
      do @(posedge clock); while (!req_ready);
      pending_ticks.push_back(advance_bus(start, sda));
      sent_ticks++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_ticks.size() != 0);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         i2chsr_pkg::CSR_SENSOR_ADDRESS: reg_address = data[6:0];
         i2chsr_pkg::CSR_MEASURE_WAIT: reg_wait = data;
         i2chsr_pkg::CSR_ACK_TIMEOUT: reg_timeout = data[7:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // registers change only with every tick answered
   task automatic set_registers(input logic [6:0] addr, input logic [15:0] wait_ticks,
                                input logic [7:0] timeout);
      wait_for_results();
      repeat (2) @(posedge clock);
      write_csr(i2chsr_pkg::CSR_SENSOR_ADDRESS, {9'($urandom_range(0, 511)), addr});
      write_csr(i2chsr_pkg::CSR_MEASURE_WAIT, wait_ticks);
      write_csr(i2chsr_pkg::CSR_ACK_TIMEOUT, {8'($urandom_range(0, 255)), timeout});
   endtask

   task automatic run_measurement(input logic noisy);
      send_tick(1'b1, sensor_sda());
      while (bus_phase != i2chsr_pkg::PH_IDLE)
         send_tick(noisy ? 1'($urandom_range(0, 1)) : 1'b0, sensor_sda());
   endtask

   // one tick of random traffic, a new measurement set up now and then while idle
   task automatic random_tick();
      if (bus_phase == i2chsr_pkg::PH_IDLE && $urandom_range(0, 3) == 0) begin
         if ($urandom_range(0, 2) == 0)
            set_registers(7'($urandom_range(0, 127)), 16'($urandom_range(1, 12)),
                          8'($urandom_range(1, 6)));
         plan_reading(pick_word(), pick_word());
         ack_pct_write = ($urandom_range(0, 9) == 0) ? 0 :
                         ($urandom_range(0, 1) ? 100 : $urandom_range(30, 99));
         ack_pct_read = ($urandom_range(0, 4) == 0) ? 0 :
                        ($urandom_range(0, 1) ? 100 : $urandom_range(30, 99));
         send_tick(1'b1, sensor_sda());
      end else if (bus_phase == i2chsr_pkg::PH_IDLE) begin
         send_tick(1'b0, sensor_sda());
      end else begin
         send_tick(1'($urandom_range(0, 1)), sensor_sda());
      end
   endtask

   // idle ticks straight out of reset
   task automatic test_idle_ticks();
      repeat (20) send_tick(1'b0, 1'($urandom_range(0, 1)));
   endtask

   // one full measurement with the reset address and time-out, wait cut short
   // before its first use, reading just below the low range limit
   task automatic test_reset_settings();
      plan_reading(16'd9362, 16'hFFFF);
      ack_pct_write = 100;
      ack_pct_read = 100;
      send_tick(1'b1, sensor_sda());
      wait_for_results();
      write_csr(i2chsr_pkg::CSR_MEASURE_WAIT, 16'd2);
      while (bus_phase != i2chsr_pkg::PH_IDLE)
         send_tick(1'b0, sensor_sda());
   endtask

   // acknowledge time-outs in both passes, stored bytes come back unchanged
   task automatic test_ack_timeouts();
      set_registers(7'd0, 16'd2, 8'd1);
      write_csr(CSR_UNUSED, 16'hFFFF);
      plan_reading(16'h1234, 16'h4321);
      ack_pct_write = 0;
      ack_pct_read = 0;
      run_measurement(1'b0);
   endtask

   // shortest wait, requests while busy, reading just above the high range limit
   task automatic test_conversion_limits();
      set_registers(7'd127, 16'd1, 8'd4);
      ack_pct_write = 100;
      ack_pct_read = 100;
      plan_reading(16'd63663, 16'd0);
      run_measurement(1'b1);
   endtask

   // random traffic under each idling pattern in turn
   task automatic test_random_traffic();
      int unsigned send_pcts [3] = '{31, 86, 0};
      int unsigned take_pcts [3] = '{86, 31, 0};
      for (int m = 0; m < 3; m++) begin
         send_idle_pct = send_pcts[m];
         take_idle_pct = take_pcts[m];
         repeat (RANDOM_TICKS_PER_MODE) random_tick();
      end
      send_idle_pct = 0;
      take_idle_pct = 0;
   endtask

   // long receiver hold-off that stalls the input, plus sender pauses to drain
   task automatic test_back_pressure();
      int unsigned mark;
      hold_request = 80;
      mark = sent_ticks;
      while (sent_ticks - mark < PRESSURE_TICKS) begin
         if ((sent_ticks - mark) % 50 == 49) wait_for_results();
         random_tick();
      end
   endtask

   // receiver: random ready, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_request != 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_request - 1;
         hold_request = 0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= take_idle_pct);
      end
   end

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fault_count++;
      end
   endtask

   // compare each taken result item with the oldest expected tick
   always @(posedge clock) begin
      bus_tick_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_ticks.size() == 0) begin
            $error("result item with no tick outstanding");
            fault_count++;
         end else begin
            want = pending_ticks.pop_front();
            check_field("scl_level", want.scl, rsp_scl_level);
            check_field("sda_drive", want.sda, rsp_sda_drive);
            check_field("sda_enable", want.en, rsp_sda_enable);
            check_field("busy_res", want.busy, rsp_busy_res);
            check_field("result_valid", want.done, rsp_result_valid);
            check_field("read_nack", want.nack, rsp_read_nack);
            check_field("temperature_raw", want.temp_raw, rsp_temperature_raw);
            check_field("humidity_raw", want.hum_raw, rsp_humidity_raw);
            check_field("temperature_hundredths", $signed(want.temp_c100),
                        rsp_temperature_hundredths);
            check_field("humidity_hundredths", want.hum_c100, rsp_humidity_hundredths);
            check_field("in_range", want.in_range, rsp_in_range);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_ticks();
      test_reset_settings();
      test_ack_timeouts();
      test_conversion_limits();
      test_random_traffic();
      test_back_pressure();
      wait_for_results();
      repeat (4) @(posedge clock);
      if (fault_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== i2c_humidity_sensor_reader_core.f =====
+incdir+rtl
rtl/i2chsr_pkg.sv
rtl/i2c_humidity_sensor_reader_core.sv
bench/tb.sv
